### design/bde3_pkg.sv
// ----------------------------------------------------------------------------
// bde3_pkg
// Shared types and constants for the 3x3 binary dilation / erosion block.
// ----------------------------------------------------------------------------
`default_nettype none

package bde3_pkg;

    localparam logic [7:0]  FG_THRESHOLD = 8'd127;
    localparam logic [7:0]  FG_VALUE     = 8'd255;
    localparam logic [7:0]  BG_VALUE     = 8'd0;
    localparam logic [8:0]  CROSS_MASK   = 9'h0BA;

    localparam int          CFG_IDX_W    = 2;
    localparam int          CFG_DATA_W   = 11;
    localparam int          POS_W        = 10;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx    REG_MORPH_MODE   = 2'd0;
    localparam t_cfg_idx    REG_FRAME_WIDTH  = 2'd1;
    localparam t_cfg_idx    REG_FRAME_HEIGHT = 2'd2;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 11'd480;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             fg;
        logic             last;
    } t_result;

endpackage

`default_nettype wire

### design/binary_dilate_erode_3x3_top.sv
// ----------------------------------------------------------------------------
// binary_dilate_erode_3x3_top
// Streaming 3x3 binary morphology on a raster-order grayscale pixel stream.
// ----------------------------------------------------------------------------
// One pixel is taken per clock while each pixel yields at most one result and
// the output is not stalled. A pixel that closes a row, or any pixel of the last
// row, can yield up to three results; these leave through a four-entry output
// buffer one per cycle while the output is not stalled. The first result of a
// pixel is registered in stage 1 and then in the output buffer before it is
// presented. The output buffer takes the results of a new pixel while one
// earlier result still waits, so the input stall never follows the output stall
// in the same cycle. The line store is read-modify-write and is one 2-bit wide
// synchronous memory of MAX_WIDTH entries holding the two earlier rows; the
// store needs no clearing pass after reset.
`default_nettype none

module binary_dilate_erode_3x3_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [bde3_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [bde3_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [7:0]                        i_pixel_value,
    input  wire logic                              i_frame_start,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [9:0]                             o_out_row,
    output logic [9:0]                             o_out_col,
    output logic [7:0]                             o_out_value,
    output logic                                   o_last_of_run
);
    import bde3_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int CDW = CW + 1;
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int RDW = RW + 1;

    // configuration
    logic                  r_mode;
    logic [CFG_DATA_W-1:0] r_width_cfg;
    logic [CFG_DATA_W-1:0] r_height_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 1'b0;
            r_width_cfg  <= WIDTH_RESET;
            r_height_cfg <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MORPH_MODE:   r_mode       <= i_cfg_data[0];
                REG_FRAME_WIDTH:  r_width_cfg  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_height_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [CDW-1:0] w_eff;
    logic [RDW-1:0] h_eff;

    always_comb begin
        if (r_width_cfg == '0)
            w_eff = CDW'(1);
        else if (32'(r_width_cfg) > MAX_WIDTH)
            w_eff = CDW'(MAX_WIDTH);
        else
            w_eff = CDW'(r_width_cfg);
        if (r_height_cfg == '0)
            h_eff = RDW'(1);
        else if (32'(r_height_cfg) > MAX_HEIGHT)
            h_eff = RDW'(MAX_HEIGHT);
        else
            h_eff = RDW'(r_height_cfg);
    end

    // position counters and stage 1 registers
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [RW-1:0] n_row;
    logic [CW-1:0] n_col;

    logic          r_s1_valid;
    logic [RW-1:0] r_s1_row;
    logic [CW-1:0] r_s1_col;
    logic          r_s1_fg;
    logic          r_s1_r1;
    logic          r_s1_c1;
    logic          r_s1_int;
    logic          r_s1_clast;
    logic          r_s1_rlast;
    logic          r_fwd_hit;
    logic [1:0]    r_fwd_data;

    logic          in_acc;
    logic          out_acc;
    logic          s1_fire;
    logic          keep_head;
    logic [2:0]    r_count;

    logic [RDW-1:0] rr;
    logic [CDW-1:0] cc;
    logic [RDW-1:0] rr_inc;
    logic [CDW-1:0] cc_inc;
    logic [CW-1:0]  rd_addr;
    logic           fg_in;

    assign out_acc   = o_valid && !i_stall;
    assign keep_head = (r_count == 3'd1) && !out_acc;
    assign s1_fire   = r_s1_valid && (r_count <= 3'd1);
    assign o_stall   = r_s1_valid && (r_count > 3'd1);
    assign in_acc    = i_valid && !o_stall;
    assign fg_in     = (i_pixel_value > FG_THRESHOLD);

    always_comb begin
        rr = i_frame_start ? '0 : RDW'(r_row);
        cc = i_frame_start ? '0 : CDW'(r_col);
        if (cc >= w_eff) begin
            cc = '0;
            rr = rr + RDW'(1);
        end
        if (rr >= h_eff)
            rr = '0;
        rd_addr = cc[CW-1:0];

        cc_inc = cc + CDW'(1);
        rr_inc = rr + RDW'(1);
        n_col  = cc_inc[CW-1:0];
        n_row  = rr[RW-1:0];
        if (cc_inc >= w_eff) begin
            n_col = '0;
            n_row = (rr_inc >= h_eff) ? '0 : rr_inc[RW-1:0];
        end
    end

    // line store: bit 1 row r-1, bit 0 row r-2
    logic [1:0] mem_lines [MAX_WIDTH];
    logic [1:0] r_mem_q;
    logic [1:0] wr_data;
    logic [1:0] lines;

    assign lines   = r_fwd_hit ? r_fwd_data : r_mem_q;
    assign wr_data = {r_s1_fg, lines[1]};

    always_ff @(posedge i_clk) begin
        if (s1_fire)
            mem_lines[r_s1_col] <= wr_data;
        if (in_acc)
            r_mem_q <= mem_lines[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (in_acc)
                r_s1_valid <= 1'b1;
            else if (s1_fire)
                r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_row   <= rr[RW-1:0];
            r_s1_col   <= rd_addr;
            r_s1_fg    <= fg_in;
            r_s1_r1    <= (rr != '0);
            r_s1_c1    <= (cc != '0);
            r_s1_int   <= (rr >= RDW'(2)) && (cc >= CDW'(2));
            r_s1_clast <= (cc == w_eff - CDW'(1));
            r_s1_rlast <= (rr == h_eff - RDW'(1));
            r_fwd_hit  <= s1_fire && (r_s1_col == rd_addr);
            r_fwd_data <= wr_data;
        end
    end

    // window and results
    logic [8:0] r_window;
    logic [8:0] n_window;
    logic       bit_main;
    t_result    res [3];
    logic [2:0] res_en;
    t_result    packed_res [3];
    logic [1:0] n_res;
    logic [RW-1:0] row_m1;
    logic [CW-1:0] col_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_window <= '0;
        else if (s1_fire)
            r_window <= n_window;
    end

    always_comb begin
        n_window = {r_window[5:0], r_s1_fg, lines[1], lines[0]};
        if (r_s1_int)
            bit_main = r_mode ? ((n_window & CROSS_MASK) == CROSS_MASK) : (n_window != '0);
        else
            bit_main = n_window[4];

        row_m1 = r_s1_row - RW'(1);
        col_m1 = r_s1_col - CW'(1);

        res[0] = '{row: POS_W'(row_m1), col: POS_W'(col_m1), fg: bit_main, last: 1'b0};
        res[1] = '{row: POS_W'(row_m1), col: POS_W'(r_s1_col), fg: n_window[1],
                   last: 1'b0};
        res[2] = '{row: POS_W'(r_s1_row), col: POS_W'(r_s1_col), fg: r_s1_fg,
                   last: 1'b0};
        res_en[0] = r_s1_r1 && r_s1_c1;
        res_en[1] = r_s1_r1 && r_s1_clast;
        res_en[2] = r_s1_rlast;

        packed_res[0] = res[0];
        packed_res[1] = res[1];
        packed_res[2] = res[2];
        n_res = 2'd0;
        for (int k = 0; k < 3; k++) begin
            if (res_en[k]) begin
                packed_res[n_res] = res[k];
                n_res = n_res + 2'd1;
            end
        end
        if (n_res != 2'd0)
            packed_res[n_res - 2'd1].last = 1'b1;
    end

    // output buffer: slot 0 is presented
    t_result r_slot [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd0;
        end else if (s1_fire) begin
            r_count <= (keep_head ? 3'd1 : 3'd0) + {1'b0, n_res};
        end else if (out_acc) begin
            r_count <= r_count - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            if (keep_head) begin
                r_slot[1] <= packed_res[0];
                r_slot[2] <= packed_res[1];
                r_slot[3] <= packed_res[2];
            end else begin
                r_slot[0] <= packed_res[0];
                r_slot[1] <= packed_res[1];
                r_slot[2] <= packed_res[2];
            end
        end else if (out_acc) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
            r_slot[2] <= r_slot[3];
        end
    end

    assign o_valid       = (r_count != 3'd0);
    assign o_out_row     = r_slot[0].row;
    assign o_out_col     = r_slot[0].col;
    assign o_out_value   = r_slot[0].fg ? FG_VALUE : BG_VALUE;
    assign o_last_of_run = r_slot[0].last;

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("result buffer count out of range");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 3'd1) |-> r_slot[0].last)
        else $error("final buffered result lacks the last flag");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_fire) |=> (r_s1_valid && $stable(r_s1_col) && $stable(r_mem_q)))
        else $error("stalled stage lost its item or line data");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (!r_s1_valid || s1_fire))
        else $error("pixel taken while stage 1 is occupied");

    a_fire_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && n_res == 2'd0 && !keep_head) |=> !o_valid)
        else $error("output valid after a pixel with no results");

endmodule

`default_nettype wire
